// ===== rtl/ecsz_pkg.sv =====
package ecsz_pkg;

  localparam int unsigned OrderLen = 19;
  localparam int unsigned IdxW     = 5;

  typedef struct packed {
    logic [2:0] n;
    logic [1:0] l;
    logic [3:0] cap;
  } sub_t;

  function automatic sub_t order_entry(input logic [IdxW-1:0] idx);
    sub_t s;
    s = '0;
    unique case (idx)
      5'd0:  s = '{3'd1, 2'd0, 4'd2};
      5'd1:  s = '{3'd2, 2'd0, 4'd2};
      5'd2:  s = '{3'd2, 2'd1, 4'd6};
      5'd3:  s = '{3'd3, 2'd0, 4'd2};
      5'd4:  s = '{3'd3, 2'd1, 4'd6};
      5'd5:  s = '{3'd4, 2'd0, 4'd2};
      5'd6:  s = '{3'd3, 2'd2, 4'd10};
      5'd7:  s = '{3'd4, 2'd1, 4'd6};
      5'd8:  s = '{3'd5, 2'd0, 4'd2};
      5'd9:  s = '{3'd4, 2'd2, 4'd10};
      5'd10: s = '{3'd5, 2'd1, 4'd6};
      5'd11: s = '{3'd6, 2'd0, 4'd2};
      5'd12: s = '{3'd4, 2'd3, 4'd14};
      5'd13: s = '{3'd5, 2'd2, 4'd10};
      5'd14: s = '{3'd6, 2'd1, 4'd6};
      5'd15: s = '{3'd7, 2'd0, 4'd2};
      5'd16: s = '{3'd5, 2'd3, 4'd14};
      5'd17: s = '{3'd6, 2'd2, 4'd10};
      5'd18: s = '{3'd7, 2'd1, 4'd6};
      default: s = '0;
    endcase
    return s;
  endfunction

  // Exception layout count at a position; the rest of each layout matches the order.
  function automatic logic [3:0] exc_count(input logic [1:0] e, input logic [IdxW-1:0] idx,
                                           input logic [3:0] cap);
    logic [3:0] c;
    c = cap;
    unique case (e)
      2'd0: if (idx == 5'd5) c = 4'd1; else if (idx == 5'd6) c = 4'd5;
      2'd1: if (idx == 5'd5) c = 4'd1;
      2'd2: if (idx == 5'd8) c = 4'd1; else if (idx == 5'd9) c = 4'd4;
      2'd3: if (idx == 5'd5 || idx == 5'd8) c = 4'd1; else if (idx == 5'd9) c = 4'd5;
      default: c = cap;
    endcase
    return c;
  endfunction

  // Sigma weight of one subshell in twentieths per electron (same group handled apart).
  function automatic logic [4:0] shield_wt(input logic [2:0] sn, input logic [1:0] sl,
                                           input logic [2:0] tn, input logic [1:0] tl);
    logic [4:0] w;
    logic [3:0] tn4;
    w = 5'd0;
    tn4 = {1'b0, tn};
    if (tl <= 2'd1) begin
      if (sn == tn) w = (sl <= 2'd1) ? 5'd0 : 5'd20;
      else if ({1'b0, sn} + 4'd1 == tn4) w = (sl <= 2'd1) ? 5'd17 : 5'd20;
      else if ({1'b0, sn} + 4'd2 <= tn4) w = 5'd20;
    end else begin
      if (sn < tn || (sn == tn && sl < tl)) w = 5'd20;
    end
    return w;
  endfunction

  function automatic logic is_same(input logic [2:0] sn, input logic [1:0] sl,
                                   input logic [2:0] tn, input logic [1:0] tl);
    return (tl <= 2'd1) ? (sn == tn && sl <= 2'd1) : (sn == tn && sl == tl);
  endfunction

endpackage

// ===== rtl/electron_config_slater_zeff.sv =====
// Builds the aufbau configuration of an atom or ion and its Slater Zeff. One input beat
// yields one output beat per filled subshell (up to 19), in filling order; the last beat
// carries sigma (twentieths) and Zeff (thousandths). A bare nucleus yields a single beat.
// Timing: an accepted item waits in the input register and loads into the sequencer; the
// sequencer then walks one subshell per cycle, while the shielding stage can take a beat,
// into the shielding stage, and the output register then takes each beat. A bare nucleus
// skips the sequencer and loads straight into the shielding stage. The next item is
// accepted while the sequencer works and loads once the sequencer is idle and the
// shielding stage can take a beat; bare nuclei are paced by the input register, which
// accepts a new item only while it is empty. Output stalls hold every stage
// and, through the input register, raise stall_o.
module electron_config_slater_zeff (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [6:0]  atomic_number_i,
  input  logic [7:0]  charge_state_i,
  input  logic [2:0]  target_n_i,
  input  logic [1:0]  target_l_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [2:0]  shell_n_o,
  output logic [1:0]  shell_l_o,
  output logic [3:0]  electron_count_o,
  output logic        bare_nucleus_o,
  output logic        exception_used_o,
  output logic [11:0] sigma_twentieths_o,
  output logic [16:0] zeff_milli_o,
  output logic        last_o
);
  import ecsz_pkg::*;

  logic       load;
  logic       front_busy;
  logic [6:0] z_w;
  logic [7:0] ne_w;
  logic [2:0] tn_w;
  logic [1:0] tl_w;
  logic       exc_w;
  logic [1:0] sel_w;

  // Sequencer state.
  logic             busy_q, busy_d;
  logic [IdxW-1:0]  idx_q;
  logic [7:0]       left_q;
  logic [6:0]       z_q;
  logic [2:0]       tn_q;
  logic [1:0]       tl_q;
  logic             exc_q;
  logic [1:0]       sel_q;
  logic [11:0]      acc_q;
  logic             seen_q;

  // Shielding stage: one subshell beat with its running sigma sum.
  logic             a_valid_q, a_valid_d;
  logic [2:0]       a_n_q;
  logic [1:0]       a_l_q;
  logic [3:0]       a_cnt_q;
  logic             a_bare_q, a_exc_q, a_last_q, a_seen_q;
  logic [11:0]      a_acc_q;
  logic [6:0]       a_z_q;
  logic [2:0]       a_f_q;

  // Output register.
  logic             ovalid_q, ovalid_d;
  logic [2:0]       n_q;
  logic [1:0]       l_q;
  logic [3:0]       cnt_q;
  logic             bare_q, excu_q, last_q;
  logic [11:0]      sig_q;
  logic [16:0]      zf_q;

  sub_t        ent;
  logic [3:0]  cnt;
  logic [7:0]  left_d;
  logic        fin, same_hit;
  logic [4:0]  wt, wsel;
  logic [2:0]  factor;
  logic [11:0] acc_d;
  logic        seen_d;
  logic        step, a_free, b_free;
  logic [11:0] sig_w;
  logic [17:0] zf_full;

  ecsz_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .atomic_number_i, .charge_state_i, .target_n_i, .target_l_i,
    .load_o(load), .busy_i(front_busy),
    .z_o(z_w), .ne_o(ne_w), .tn_o(tn_w), .tl_o(tl_w), .exc_o(exc_w), .exc_sel_o(sel_w)
  );

  assign b_free     = !ovalid_q || !stall_i;
  assign a_free     = !a_valid_q || b_free;
  // Hold the next item until the sequencer is idle and the shielding stage can take a beat.
  assign front_busy = busy_q || !a_free;
  assign step       = busy_q && a_free;

  // Walk the filling order one subshell a cycle while the shielding stage is free. Same-group
  // electrons are summed at the group factor; the first one is taken back in the shielding stage.
  always_comb begin
    ent = order_entry(idx_q);
    if (exc_q) cnt = exc_count(sel_q, idx_q, ent.cap);
    else cnt = (left_q < {4'd0, ent.cap}) ? left_q[3:0] : ent.cap;
    left_d = left_q - {4'd0, cnt};
    if (exc_q) fin = (sel_q[1] ? (idx_q == 5'd9) : (idx_q == 5'd6));
    else fin = (left_d == 8'd0) || (idx_q == 5'(OrderLen - 1));
    same_hit = is_same(ent.n, ent.l, tn_q, tl_q);
    wt = shield_wt(ent.n, ent.l, tn_q, tl_q);
    factor = (tn_q == 3'd1 && tl_q <= 2'd1) ? 3'd6 : 3'd7;
    wsel = same_hit ? {2'b00, factor} : wt;
    acc_d = acc_q + {7'd0, wsel} * {8'd0, cnt};
    seen_d = seen_q || (same_hit && cnt != 4'd0);
  end

  // Handshake between the stages.
  always_comb begin
    busy_d = busy_q;
    if (load && ne_w != 8'd0) busy_d = 1'b1;
    else if (step && fin) busy_d = 1'b0;
    a_valid_d = a_valid_q && !b_free;
    if ((load && ne_w == 8'd0) || step) a_valid_d = 1'b1;
    ovalid_d = b_free ? a_valid_q : 1'b1;
  end

  // Finish shielding: drop one same-group electron, then Zeff = 1000 Z - 50 sigma.
  always_comb begin
    sig_w = a_acc_q - (a_seen_q ? {9'd0, a_f_q} : 12'd0);
    zf_full = {11'd0, a_z_q} * 18'd1000 - {6'd0, sig_w} * 18'd50;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      a_valid_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      a_valid_q <= a_valid_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      idx_q <= '0; left_q <= ne_w; z_q <= z_w; tn_q <= tn_w; tl_q <= tl_w;
      exc_q <= exc_w; sel_q <= sel_w; acc_q <= '0; seen_q <= 1'b0;
    end else if (step) begin
      idx_q <= idx_q + 5'd1; left_q <= left_d; acc_q <= acc_d; seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && ne_w == 8'd0) begin
      // Bare nucleus: a single beat straight into the shielding stage.
      a_n_q <= '0; a_l_q <= '0; a_cnt_q <= '0; a_bare_q <= 1'b1; a_exc_q <= 1'b0;
      a_last_q <= 1'b1; a_acc_q <= '0; a_seen_q <= 1'b0; a_z_q <= z_w; a_f_q <= 3'd7;
    end else if (step) begin
      a_n_q <= ent.n; a_l_q <= ent.l; a_cnt_q <= cnt; a_bare_q <= 1'b0; a_exc_q <= exc_q;
      a_last_q <= fin; a_acc_q <= acc_d; a_seen_q <= seen_d; a_z_q <= z_q; a_f_q <= factor;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && b_free) begin
      n_q <= a_n_q; l_q <= a_l_q; cnt_q <= a_cnt_q; bare_q <= a_bare_q; excu_q <= a_exc_q;
      last_q <= a_last_q;
      sig_q <= a_last_q ? sig_w : 12'd0;
      zf_q <= !a_last_q ? 17'd0 : (zf_full[17] || zf_full == 18'd0) ? 17'd1 : zf_full[16:0];
    end
  end

  assign valid_o = ovalid_q;
  assign shell_n_o = n_q;
  assign shell_l_o = l_q;
  assign electron_count_o = cnt_q;
  assign bare_nucleus_o = bare_q;
  assign exception_used_o = excu_q;
  assign sigma_twentieths_o = sig_q;
  assign zeff_milli_o = zf_q;
  assign last_o = last_q;

  a_bare_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && bare_nucleus_o |-> last_o) else $error("bare beat not last");
  a_zeff_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |-> zeff_milli_o != 17'd0) else $error("zeff zero");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(last_o)) else $error("beat lost");
endmodule

// ===== rtl/ecsz_front.sv =====
module ecsz_front (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [6:0] atomic_number_i,
  input  logic [7:0] charge_state_i,
  input  logic [2:0] target_n_i,
  input  logic [1:0] target_l_i,
  output logic       load_o,
  input  logic       busy_i,
  output logic [6:0] z_o,
  output logic [7:0] ne_o,
  output logic [2:0] tn_o,
  output logic [1:0] tl_o,
  output logic       exc_o,
  output logic [1:0] exc_sel_o
);
  import ecsz_pkg::*;

  logic [8:0] ne_w;
  logic       full_q;
  logic [6:0] z_q;
  logic [7:0] ne_q;
  logic [2:0] tn_q;
  logic [1:0] tl_q;
  logic       exc_q;
  logic [1:0] sel_q;

  assign ne_w = {2'b00, atomic_number_i} - {charge_state_i[7], charge_state_i};
  assign stall_o = full_q;
  assign load_o  = full_q && !busy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (valid_i && !full_q) begin
      full_q <= 1'b1;
    end else if (load_o) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !full_q) begin
      z_q  <= atomic_number_i;
      ne_q <= ne_w[8] ? 8'd0 : ne_w[7:0];
      tn_q <= target_n_i;
      tl_q <= target_l_i;
      exc_q <= (charge_state_i == 8'd0) && (atomic_number_i == 7'd24 ||
               atomic_number_i == 7'd29 || atomic_number_i == 7'd41 ||
               atomic_number_i == 7'd42);
      sel_q <= (atomic_number_i == 7'd24) ? 2'd0 : (atomic_number_i == 7'd29) ? 2'd1 :
               (atomic_number_i == 7'd41) ? 2'd2 : 2'd3;
    end
  end

  assign z_o = z_q;
  assign ne_o = ne_q;
  assign tn_o = tn_q;
  assign tl_o = tl_q;
  assign exc_o = exc_q;
  assign exc_sel_o = sel_q;
endmodule

// ===== bench/electron_config_slater_zeff_tb.sv =====
`timescale 1ns / 100ps

module electron_config_slater_zeff_tb;

  // One expected output beat of the configuration stream.
  typedef struct packed {
    logic [2:0]  n;
    logic [1:0]  l;
    logic [3:0]  cnt;
    logic        bare;
    logic        exc;
    logic [11:0] sigma;
    logic [16:0] zeff;
    logic        last;
  } shell_beat_t;

  // One request: nucleus, ion charge and the target subshell.
  typedef struct packed {
    logic [6:0] z;
    logic [7:0] q;
    logic [2:0] tn;
    logic [1:0] tl;
  } atom_req_t;

  localparam int unsigned CycleLimit = 400000;

  logic        clk;
  logic        rst_n;
  logic        valid_in;
  logic        stall_out;
  logic [6:0]  atomic_number;
  logic [7:0]  charge_state;
  logic [2:0]  target_n;
  logic [1:0]  target_l;
  logic        valid_out;
  logic        stall_in;
  logic [2:0]  shell_n;
  logic [1:0]  shell_l;
  logic [3:0]  electron_count;
  logic        bare_nucleus;
  logic        exception_used;
  logic [11:0] sigma_twentieths;
  logic [16:0] zeff_milli;
  logic        last;

  atom_req_t   pending_reqs[$];
  shell_beat_t expected_beats[$];

  int unsigned n_errors   = 0;
  int unsigned n_beats    = 0;
  int unsigned n_sent     = 0;
  int unsigned n_exc      = 0;
  int unsigned n_bare     = 0;
  int unsigned cycle      = 0;
  bit          stim_done  = 1'b0;
  bit          drain_hold = 1'b0;  // sender pauses while set
  bit          long_hold  = 1'b0;  // receiver holds off while set
  int unsigned src_gap    = 0;
  int unsigned snk_gap    = 0;

  electron_config_slater_zeff DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .valid_i            (valid_in),
    .stall_o            (stall_out),
    .atomic_number_i    (atomic_number),
    .charge_state_i     (charge_state),
    .target_n_i         (target_n),
    .target_l_i         (target_l),
    .valid_o            (valid_out),
    .stall_i            (stall_in),
    .shell_n_o          (shell_n),
    .shell_l_o          (shell_l),
    .electron_count_o   (electron_count),
    .bare_nucleus_o     (bare_nucleus),
    .exception_used_o   (exception_used),
    .sigma_twentieths_o (sigma_twentieths),
    .zeff_milli_o       (zeff_milli),
    .last_o             (last)
  );

  // 8 ns clock.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Aufbau order and capacities, kept here independently of the package.
  function automatic void order_slot(input int idx, output int n, output int l,
                                     output int cap);
    int t[19][3];
    t = '{'{1,0,2}, '{2,0,2}, '{2,1,6}, '{3,0,2}, '{3,1,6}, '{4,0,2}, '{3,2,10},
          '{4,1,6}, '{5,0,2}, '{4,2,10}, '{5,1,6}, '{6,0,2}, '{4,3,14}, '{5,2,10},
          '{6,1,6}, '{7,0,2}, '{5,3,14}, '{6,2,10}, '{7,1,6}};
    n   = t[idx][0];
    l   = t[idx][1];
    cap = t[idx][2];
  endfunction

  // Build the subshell layout for one request and queue its beats, sigma and
  // Zeff riding on the final one.
  function automatic void predict_config(input atom_req_t r);
    int z, chg, ne, k, left, n, l, cap, f, sig, same, zf, exc_sel;
    int sn[19], sl[19], se[19];
    shell_beat_t b;
    z   = r.z;
    chg = $signed(r.q);
    ne  = z - chg;
    if (ne < 0) ne = 0;
    if (ne == 0) begin
      b = '0;
      b.bare = 1'b1;
      b.zeff = (z * 1000 < 1) ? 17'd1 : 17'(z * 1000);
      b.last = 1'b1;
      expected_beats = {expected_beats, b};
      n_bare++;
      return;
    end
    exc_sel = -1;
    if (chg == 0) begin
      case (z)
        24: exc_sel = 0;
        29: exc_sel = 1;
        41: exc_sel = 2;
        42: exc_sel = 3;
        default: exc_sel = -1;
      endcase
    end
    k = 0;
    if (exc_sel >= 0) begin
      // Exceptions follow the normal order, with a few slots trimmed.
      for (int i = 0; i < ((exc_sel < 2) ? 7 : 10); i++) begin
        order_slot(i, n, l, cap);
        sn[k] = n; sl[k] = l; se[k] = cap;
        if (exc_sel == 0 && i == 5) se[k] = 1;
        if (exc_sel == 0 && i == 6) se[k] = 5;
        if (exc_sel == 1 && i == 5) se[k] = 1;
        if (exc_sel == 2 && i == 8) se[k] = 1;
        if (exc_sel == 2 && i == 9) se[k] = 4;
        if (exc_sel == 3 && (i == 5 || i == 8)) se[k] = 1;
        if (exc_sel == 3 && i == 9) se[k] = 5;
        k++;
      end
      n_exc++;
    end else begin
      left = ne;
      for (int i = 0; i < 19 && left > 0; i++) begin
        order_slot(i, n, l, cap);
        f = (left < cap) ? left : cap;
        sn[k] = n; sl[k] = l; se[k] = f;
        k++;
        left -= f;
      end
    end
    // Slater shielding in twentieths.
    sig  = 0;
    same = 0;
    n = r.tn;
    l = r.tl;
    for (int i = 0; i < k; i++) begin
      if (l <= 1 ? (sn[i] == n && sl[i] <= 1) : (sn[i] == n && sl[i] == l))
        same += se[i];
    end
    if (same > 1) sig += ((l <= 1 && n == 1) ? 6 : 7) * (same - 1);
    for (int i = 0; i < k; i++) begin
      if (l <= 1) begin
        if (sn[i] == n && sl[i] <= 1) continue;
        if (sn[i] == n) sig += 20 * se[i];
        else if (sn[i] == n - 1) sig += ((sl[i] <= 1) ? 17 : 20) * se[i];
        else if (sn[i] <= n - 2) sig += 20 * se[i];
      end else begin
        if (sn[i] == n && sl[i] == l) continue;
        if (sn[i] < n || (sn[i] == n && sl[i] < l)) sig += 20 * se[i];
      end
    end
    zf = z * 1000 - 50 * sig;
    if (zf < 1) zf = 1;
    for (int i = 0; i < k; i++) begin
      b = '0;
      b.n   = 3'(sn[i]);
      b.l   = 2'(sl[i]);
      b.cnt = 4'(se[i]);
      b.exc = (exc_sel >= 0);
      if (i == k - 1) begin
        b.sigma = 12'(sig);
        b.zeff  = 17'(zf);
        b.last  = 1'b1;
      end
      expected_beats = {expected_beats, b};
    end
  endfunction

  function automatic void add_req(input int z, input int q, input int tn, input int tl);
    atom_req_t r;
    r.z  = 7'(z);
    r.q  = 8'(q);
    r.tn = 3'(tn);
    r.tl = 2'(tl);
    pending_reqs = {pending_reqs, r};
  endfunction

  // Mostly short gaps, a few long ones, sometimes none for a stretch.
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Driver: present the head of the request queue, advance on acceptance.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      valid_in      <= 1'b0;
      atomic_number <= '0;
      charge_state  <= '0;
      target_n      <= '0;
      target_l      <= '0;
      src_gap       <= 0;
    end else begin
      if (valid_in && !stall_out) begin
        predict_config({atomic_number, charge_state, target_n, target_l});
        n_sent++;
      end
      if (valid_in && stall_out) begin
        // hold the beat
      end else if (src_gap != 0) begin
        src_gap  <= src_gap - 1;
        valid_in <= 1'b0;
      end else if (pending_reqs.size() != 0 && !drain_hold) begin
        {atomic_number, charge_state, target_n, target_l} <= pending_reqs.pop_front();
        valid_in <= 1'b1;
        src_gap  <= pick_gap();
      end else begin
        valid_in <= 1'b0;
      end
    end
  end

  // Monitor: random receiver stalls, compare each accepted beat.
  always @(posedge clk or negedge rst_n) begin
    shell_beat_t exp_b;
    shell_beat_t got_b;
    if (!rst_n) begin
      stall_in <= 1'b0;
      snk_gap  <= 0;
    end else begin
      if (valid_out && !stall_in) begin
        got_b = {shell_n, shell_l, electron_count, bare_nucleus, exception_used,
                 sigma_twentieths, zeff_milli, last};
        n_beats++;
        if (expected_beats.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected beat %p", got_b);
        end else begin
          exp_b = expected_beats.pop_front();
          if (got_b !== exp_b) begin
            n_errors++;
            if (n_errors <= 10) $display("mismatch: expected %p got %p", exp_b, got_b);
          end
        end
      end
      if (long_hold) begin
        stall_in <= 1'b1;
      end else if (snk_gap != 0) begin
        snk_gap  <= snk_gap - 1;
        stall_in <= 1'b1;
      end else begin
        stall_in <= 1'b0;
        snk_gap  <= pick_gap();
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Long receiver hold-off, counted in its own process, once the random part is queued.
  initial begin
    wait (stim_done);
    repeat (100) @(posedge clk);
    long_hold = 1'b1;
    repeat (300) @(posedge clk);
    long_hold = 1'b0;
  end

  initial begin
    int z, q, p;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b0;
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, bare nucleus, exceptions, ions of exception Z, overflow.
    add_req(0, 0, 1, 0);        // bare nucleus, Z 0
    add_req(1, 1, 1, 0);        // bare ion
    add_req(127, 127, 7, 3);    // bare, largest Z
    add_req(5, 100, 2, 1);      // charge larger than Z
    add_req(1, 0, 1, 0);
    add_req(2, 0, 1, 0);
    add_req(24, 0, 3, 2);       // chromium layout
    add_req(29, 0, 4, 0);       // copper layout
    add_req(41, 0, 4, 2);       // niobium layout
    add_req(42, 0, 5, 0);       // molybdenum layout
    add_req(24, 1, 3, 2);       // ion with exception Z
    add_req(29, -1, 4, 0);
    add_req(42, 2, 4, 2);
    add_req(118, 0, 7, 1);
    add_req(127, -16, 5, 3);    // overflow past 118
    add_req(120, 0, 6, 2);
    add_req(26, 0, 0, 0);       // target n 0
    add_req(26, 0, 0, 3);
    add_req(80, 0, 7, 3);
    add_req(57, 0, 4, 3);
    add_req(11, 0, 3, 1);
    add_req(30, 0, 3, 2);
    add_req(127, 0, 1, 0);      // largest Z, neutral, 1s target
    add_req(3, 0, 7, 0);

    // Pause the sender until every expected beat has come out.
    wait (pending_reqs.size() == 0 && !valid_in);
    @(posedge clk);
    drain_hold = 1'b1;
    wait (expected_beats.size() == 0);
    @(posedge clk);
    drain_hold = 1'b0;

    for (int i = 0; i < 256; i++) begin
      p = $urandom_range(99);
      z = $urandom_range(127);
      if (p < 60) q = $urandom_range(6) - 3;                  // near-neutral
      else if (p < 70) q = 0;
      else if (p < 85) q = $signed(8'($urandom_range(255)));  // any code
      else q = $urandom_range(127);
      if (p >= 98) begin
        case ($urandom_range(3))
          0: z = 24;
          1: z = 29;
          2: z = 41;
          default: z = 42;
        endcase
        q = 0;
      end
      add_req(z, q, $urandom_range(7), $urandom_range(3));
    end
    stim_done = 1'b1;

    wait (pending_reqs.size() == 0 && !valid_in);
    wait (expected_beats.size() == 0);
    repeat (50) @(posedge clk);

    $display("Sent %0d requests (%0d bare, %0d exception layouts), checked %0d beats.",
             n_sent, n_bare, n_exc, n_beats);
    if (n_errors == 0 && expected_beats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== electron_config_slater_zeff.f =====
rtl/ecsz_pkg.sv
rtl/ecsz_front.sv
rtl/electron_config_slater_zeff.sv
bench/electron_config_slater_zeff_tb.sv
